// ----- rtl/edac_pkg.sv -----
// Shared types and constants for the echo distance averager and classifier.
// Holds controller/datapath command and status structs and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package edac_pkg;

    localparam int WINDOW_LEN_DEF = 8;

    localparam int DIST_W   = 13;
    localparam int DUR_W    = 15;
    localparam int LIGHT_W  = 12;
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 8;
    localparam int CFG_W    = 16;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;
    localparam int PROD_W   = 26;
    localparam int MUL_W    = 11;

    localparam logic [MUL_W-1:0]   DIST_MUL   = 11'd1114;
    localparam int                 DIST_SHIFT = 12;
    localparam logic [LIGHT_W-1:0] LIGHT_FULL = 12'hFFF;

    localparam logic [IDX_W-1:0] REG_VALID_MIN    = 8'd0;
    localparam logic [IDX_W-1:0] REG_VALID_MAX    = 8'd1;
    localparam logic [IDX_W-1:0] REG_TOO_CLOSE    = 8'd2;
    localparam logic [IDX_W-1:0] REG_PRESENT_MAX  = 8'd3;
    localparam logic [IDX_W-1:0] REG_LIGHT_DIM    = 8'd4;
    localparam logic [IDX_W-1:0] REG_LIGHT_NORMAL = 8'd5;
    localparam logic [IDX_W-1:0] REG_LIGHT_BRIGHT = 8'd6;
    localparam logic [IDX_W-1:0] REG_LIGHT_MODE   = 8'd7;

    localparam logic [MODE_W-1:0] MODE_ANALOG   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DARK_LOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DARK_HI  = 2'd2;

    localparam logic [1:0] BUCKET_DIM     = 2'd0;
    localparam logic [1:0] BUCKET_NORMAL  = 2'd1;
    localparam logic [1:0] BUCKET_BRIGHT  = 2'd2;
    localparam logic [1:0] BUCKET_INVALID = 2'd3;

    localparam logic [1:0] DSTATE_NONE    = 2'd0;
    localparam logic [1:0] DSTATE_CLOSE   = 2'd1;
    localparam logic [1:0] DSTATE_PRESENT = 2'd2;
    localparam logic [1:0] DSTATE_AWAY    = 2'd3;

    typedef struct packed {
        logic load_in;
        logic calc_dist;
        logic write_ring;
        logic rd_issue;
        logic div_start;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic rd_last;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/echo_distance_average_classifier.sv -----
// Top level of the echo distance averager and light classifier.
// Joins edac_ctrl and edac_dp; depends on edac_pkg.
//
// Usage:
//   s_* stream carries one sample per transfer; m_* stream returns one result
//   per sample, in order. cfg_* writes one register per transfer (index 0..7,
//   other indexes ignored); write only while no sample is in flight.
//   One sample at a time: s_tready is high only while the sequencer is idle.
//   Each sample passes through the distance multiply and the ring update;
//   when the ring holds readings, a sum sweep over the ring memory reads one
//   entry per cycle and the restoring divider yields one quotient bit per
//   cycle. With an empty ring the sweep and divide are skipped.
//   Reset clears the ring fill and cursor and loads register defaults;
//   no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the next
//   sample may be accepted and worked on, and waits only to load its result.
`timescale 1ns / 1ps

module echo_distance_average_classifier
#(
    parameter int WINDOW_LEN = edac_pkg::WINDOW_LEN_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [edac_pkg::IDX_W-1:0]  cfg_index,
    input  logic [edac_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // echo_duration_us[14:0], light_analog[26:15], light_digital[27], zero[31:28]
    input  logic [edac_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // light_value[11:0], light_bucket[13:12], distance_q4[26:14],
    // distance_valid[27], distance_state[29:28], presence[30], posture_alert[31]
    output logic [edac_pkg::OUT_W-1:0]  m_tdata
);
    import edac_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_fire;
    logic  out_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;

    edac_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    edac_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_fire  (out_fire),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- rtl/edac_ctrl.sv -----
// Sequencer for one sample: distance, ring update, sum sweep, divide, output.
// Depends on edac_pkg for the command and status structs.
`timescale 1ns / 1ps

module edac_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    output logic           in_ready,
    input  edac_pkg::stat_t stat,
    output edac_pkg::cmd_t  cmd
);
    import edac_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIST   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DVINIT = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DIST;
                end
            end
            S_DIST:
            begin
                cmd.calc_dist = 1'b1;
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_ring = 1'b1;
                state_next     = S_SUM;
            end
            S_SUM:
            begin
                if (stat.fill_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_DVINIT;
            end
            S_DVINIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/edac_dp.sv -----
// Datapath: config registers, distance multiply, reading ring memory, sum
// accumulator, restoring divider, classification and output register. Uses edac_pkg.
`timescale 1ns / 1ps

module edac_dp
#(
    parameter int WINDOW_LEN = edac_pkg::WINDOW_LEN_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_fire,
    input  logic [edac_pkg::IDX_W-1:0] cfg_index,
    input  logic [edac_pkg::CFG_W-1:0] cfg_data,
    input  logic [edac_pkg::IN_W-1:0]  in_data,
    input  logic                      out_fire,
    output logic                      out_valid,
    output logic [edac_pkg::OUT_W-1:0] out_data,
    input  edac_pkg::cmd_t             cmd,
    output edac_pkg::stat_t            stat
);
    import edac_pkg::*;

    localparam int FW  = $clog2(WINDOW_LEN + 1);
    localparam int CW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SW  = DIST_W + FW;
    localparam int DCW = $clog2(SW + 1);

    logic [DIST_W-1:0]  valid_min_reg;
    logic [DIST_W-1:0]  valid_max_reg;
    logic [DIST_W-1:0]  too_close_reg;
    logic [DIST_W-1:0]  present_max_reg;
    logic [LIGHT_W-1:0] dim_max_reg;
    logic [LIGHT_W-1:0] normal_max_reg;
    logic [LIGHT_W-1:0] bright_max_reg;
    logic [MODE_W-1:0]  mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_min_reg   <= 13'd32;
            valid_max_reg   <= 13'd6400;
            too_close_reg   <= 13'd640;
            present_max_reg <= 13'd1600;
            dim_max_reg     <= 12'd1000;
            normal_max_reg  <= 12'd2500;
            bright_max_reg  <= 12'd4095;
            mode_reg        <= MODE_ANALOG;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_VALID_MIN:    valid_min_reg   <= cfg_data[DIST_W-1:0];
                REG_VALID_MAX:    valid_max_reg   <= cfg_data[DIST_W-1:0];
                REG_TOO_CLOSE:    too_close_reg   <= cfg_data[DIST_W-1:0];
                REG_PRESENT_MAX:  present_max_reg <= cfg_data[DIST_W-1:0];
                REG_LIGHT_DIM:    dim_max_reg     <= cfg_data[LIGHT_W-1:0];
                REG_LIGHT_NORMAL: normal_max_reg  <= cfg_data[LIGHT_W-1:0];
                REG_LIGHT_BRIGHT: bright_max_reg  <= cfg_data[LIGHT_W-1:0];
                REG_LIGHT_MODE:   mode_reg        <= cfg_data[MODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    logic [DUR_W-1:0]   dur_reg;
    logic [LIGHT_W-1:0] analog_reg;
    logic               digital_reg;
    logic [DIST_W:0]    dist_reg;
    logic [PROD_W-1:0]  prod;
    logic               dist_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dur_reg     <= in_data[DUR_W-1:0];
            analog_reg  <= in_data[DUR_W+LIGHT_W-1:DUR_W];
            digital_reg <= in_data[DUR_W+LIGHT_W];
        end
        if (cmd.calc_dist)
        begin
            dist_reg <= prod[PROD_W-1:DIST_SHIFT];
        end
    end

    assign prod    = {{(PROD_W-DUR_W){1'b0}}, dur_reg} * {{(PROD_W-MUL_W){1'b0}}, DIST_MUL};
    assign dist_ok = (dist_reg != '0) && ({1'b0, valid_min_reg} <= dist_reg)
                     && (dist_reg <= {1'b0, valid_max_reg});

    logic [DIST_W-1:0] ring_mem [WINDOW_LEN];
    logic [CW-1:0]     cursor_reg;
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     idx_reg;
    logic [DIST_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [SW-1:0]     sum_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_ring && dist_ok)
        begin
            ring_mem[cursor_reg] <= dist_reg[DIST_W-1:0];
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= ring_mem[idx_reg[CW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            fill_reg     <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_issue;
            if (cmd.write_ring)
            begin
                idx_reg <= '0;
                sum_reg <= '0;
                if (dist_ok)
                begin
                    if (cursor_reg == CW'(WINDOW_LEN - 1))
                    begin
                        cursor_reg <= '0;
                    end
                    else
                    begin
                        cursor_reg <= cursor_reg + 1'b1;
                    end
                    if (fill_reg != FW'(WINDOW_LEN))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
            end
            else
            begin
                if (cmd.rd_issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    sum_reg <= sum_reg + {{(SW-DIST_W){1'b0}}, rd_data_reg};
                end
            end
        end
    end

    logic [FW-1:0]  rem_reg;
    logic [SW-1:0]  quo_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [FW:0]    rem_shift;
    logic [FW:0]    rem_sub;
    logic           rem_ge;

    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, fill_reg});
    assign rem_sub   = rem_shift - {1'b0, fill_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= DCW'(SW);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= sum_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub[FW-1:0] : rem_shift[FW-1:0];
            quo_reg <= {quo_reg[SW-2:0], rem_ge};
        end
    end

    logic [LIGHT_W-1:0] light_val;
    logic [1:0]         bucket;
    logic               have;
    logic [DIST_W-1:0]  mean;
    logic [1:0]         dstate;
    logic               pres;
    logic               alert;

    always_comb
    begin
        priority if (mode_reg == MODE_DARK_LOW)
        begin
            light_val = digital_reg ? LIGHT_FULL : '0;
        end
        else if (mode_reg == MODE_DARK_HI)
        begin
            light_val = digital_reg ? '0 : LIGHT_FULL;
        end
        else
        begin
            light_val = analog_reg;
        end

        priority if (light_val <= dim_max_reg)
        begin
            bucket = BUCKET_DIM;
        end
        else if (light_val <= normal_max_reg)
        begin
            bucket = BUCKET_NORMAL;
        end
        else if (light_val <= bright_max_reg)
        begin
            bucket = BUCKET_BRIGHT;
        end
        else
        begin
            bucket = BUCKET_INVALID;
        end

        have = (fill_reg != '0);
        mean = have ? quo_reg[DIST_W-1:0] : '0;

        priority if (!have)
        begin
            dstate = DSTATE_NONE;
        end
        else if (mean < too_close_reg)
        begin
            dstate = DSTATE_CLOSE;
        end
        else if (mean <= present_max_reg)
        begin
            dstate = DSTATE_PRESENT;
        end
        else
        begin
            dstate = DSTATE_AWAY;
        end

        pres  = have && (mean != '0) && (mean <= present_max_reg);
        alert = have && (mean != '0) && (mean < too_close_reg);
    end

    logic out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {alert, pres, dstate, have, mean, bucket, light_val};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.fill_zero = (fill_reg == '0);
    assign stat.rd_last   = ((idx_reg + 1'b1) == fill_reg);
    assign stat.div_done  = (dcnt_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_fire;

endmodule

// ----- tb/tb_echo_distance_average_classifier.sv -----
// Self-checking testbench for echo_distance_average_classifier: streams samples,
// predicts each result in a local model of the ring average and light buckets.
// Depends on edac_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_echo_distance_average_classifier;

    import edac_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [3:0]         pad;
        logic               light_digital;
        logic [LIGHT_W-1:0] light_analog;
        logic [DUR_W-1:0]   echo_duration_us;
    } sample_t;

    typedef struct packed {
        logic               posture_alert;
        logic               presence;
        logic [1:0]         distance_state;
        logic               distance_valid;
        logic [DIST_W-1:0]  distance_q4;
        logic [1:0]         light_bucket;
        logic [LIGHT_W-1:0] light_value;
    } result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    echo_distance_average_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    sample_t pending_samples [$];
    result_t expected_results [$];
    int      n_queued   = 0;
    int      n_accepted = 0;
    int      n_results  = 0;
    int      n_errors   = 0;
    logic    s_taken    = 1'b0;

    logic [DIST_W-1:0]  valid_min   = 13'd32;
    logic [DIST_W-1:0]  valid_max   = 13'd6400;
    logic [DIST_W-1:0]  close_max   = 13'd640;
    logic [DIST_W-1:0]  present_max = 13'd1600;
    logic [LIGHT_W-1:0] dim_max     = 12'd1000;
    logic [LIGHT_W-1:0] normal_max  = 12'd2500;
    logic [LIGHT_W-1:0] bright_max  = 12'd4095;
    logic [MODE_W-1:0]  light_mode  = MODE_ANALOG;

    logic [DIST_W-1:0]  reading_ring [WINDOW_LEN_DEF];
    int                 ring_cursor = 0;
    int                 ring_fill   = 0;

    task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            REG_VALID_MIN:    valid_min   = val[DIST_W-1:0];
            REG_VALID_MAX:    valid_max   = val[DIST_W-1:0];
            REG_TOO_CLOSE:    close_max   = val[DIST_W-1:0];
            REG_PRESENT_MAX:  present_max = val[DIST_W-1:0];
            REG_LIGHT_DIM:    dim_max     = val[LIGHT_W-1:0];
            REG_LIGHT_NORMAL: normal_max  = val[LIGHT_W-1:0];
            REG_LIGHT_BRIGHT: bright_max  = val[LIGHT_W-1:0];
            REG_LIGHT_MODE:   light_mode  = val[MODE_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic predict_average(input sample_t smp);
        logic [31:0]        range_q4;
        logic [31:0]        sum;
        logic [31:0]        mean;
        logic [LIGHT_W-1:0] lv;
        result_t            r;
        int                 i;
        r        = '0;
        range_q4 = (32'(smp.echo_duration_us) * 32'(DIST_MUL)) >> DIST_SHIFT;
        if (smp.echo_duration_us != 0 && range_q4 != 0 && range_q4 >= valid_min
            && range_q4 <= valid_max)
        begin
            reading_ring[ring_cursor] = range_q4[DIST_W-1:0];
            ring_cursor = (ring_cursor + 1) % WINDOW_LEN_DEF;
            if (ring_fill < WINDOW_LEN_DEF)
                ring_fill++;
        end
        if (ring_fill != 0)
        begin
            sum = 0;
            for (i = 0; i < ring_fill; i++)
                sum += 32'(reading_ring[i]);
            mean = sum / 32'(ring_fill);
            r.distance_q4    = mean[DIST_W-1:0];
            r.distance_valid = 1'b1;
            if (r.distance_q4 < close_max)
                r.distance_state = DSTATE_CLOSE;
            else if (r.distance_q4 <= present_max)
                r.distance_state = DSTATE_PRESENT;
            else
                r.distance_state = DSTATE_AWAY;
            r.presence      = (r.distance_q4 != 0 && r.distance_q4 <= present_max);
            r.posture_alert = (r.distance_q4 != 0 && r.distance_q4 < close_max);
        end
        case (light_mode)
            MODE_DARK_LOW: lv = smp.light_digital ? LIGHT_FULL : '0;
            MODE_DARK_HI:  lv = smp.light_digital ? '0 : LIGHT_FULL;
            default:       lv = smp.light_analog;
        endcase
        r.light_value = lv;
        if (lv <= dim_max)
            r.light_bucket = BUCKET_DIM;
        else if (lv <= normal_max)
            r.light_bucket = BUCKET_NORMAL;
        else if (lv <= bright_max)
            r.light_bucket = BUCKET_BRIGHT;
        else
            r.light_bucket = BUCKET_INVALID;
        expected_results.push_back(r);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t got;
        s_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                predict_average(sample_t'(s_tdata));
                n_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                n_results++;
                got = result_t'(m_tdata);
                if (expected_results.size() == 0)
                begin
                    $error("result %h with no sample outstanding", m_tdata);
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("light_value", want.light_value, got.light_value);
                    compare_field("light_bucket", want.light_bucket, got.light_bucket);
                    compare_field("distance_q4", want.distance_q4, got.distance_q4);
                    compare_field("distance_valid", want.distance_valid, got.distance_valid);
                    compare_field("distance_state", want.distance_state, got.distance_state);
                    compare_field("presence", want.presence, got.presence);
                    compare_field("posture_alert", want.posture_alert, got.posture_alert);
                end
            end
        end
    end

    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (!s_tvalid || s_taken)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending_samples.size() != 0)
            begin
                s_tdata  <= pending_samples.pop_front();
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(0, 3);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    int   rx_cycle  = 0;
    int   rx_mode   = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 48 == 0)
            rx_mode = $urandom_range(0, 3);
        // hold off once long enough for the block to back up its input
        if (!hold_done && n_results >= 60)
        begin
            hold_left = 500;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_cycle[2];
            endcase
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input int vmin, input int vmax, input int close_thr,
                                  input int present_thr, input int dim, input int normal,
                                  input int bright, input int mode);
        write_reg(REG_VALID_MIN, CFG_W'(vmin));
        write_reg(REG_VALID_MAX, CFG_W'(vmax));
        write_reg(REG_TOO_CLOSE, CFG_W'(close_thr));
        write_reg(REG_PRESENT_MAX, CFG_W'(present_thr));
        write_reg(REG_LIGHT_DIM, CFG_W'(dim));
        write_reg(REG_LIGHT_NORMAL, CFG_W'(normal));
        write_reg(REG_LIGHT_BRIGHT, CFG_W'(bright));
        write_reg(REG_LIGHT_MODE, CFG_W'(mode));
        // unmapped index, must be dropped
        write_reg(IDX_W'($urandom_range(8, 255)), CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (n_accepted != n_queued || expected_results.size() != 0);
    endtask

    task automatic push_sample(input int dur, input int la, input int ld);
        sample_t smp;
        smp                  = '0;
        smp.echo_duration_us = DUR_W'(dur);
        smp.light_analog     = LIGHT_W'(la);
        smp.light_digital    = 1'(ld);
        pending_samples.push_back(smp);
        n_queued++;
    endtask

    task automatic push_random(input int count);
        int k;
        int sel;
        int dur;
        int la;
        int target;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                dur = 0;
            else if (sel < 14)
                dur = $urandom_range(1, 200);
            else if (sel < 19)
                dur = $urandom_range(30001, 32767);
            else if (sel < 50 && valid_min <= valid_max)
            begin
                target = $urandom_range(valid_min, valid_max);
                dur    = (target * 4096) / 1114 + 1;
            end
            else
                dur = $urandom_range(1, 30000);
            case ($urandom_range(0, 4))
                0:       la = int'(dim_max) + $urandom_range(0, 2) - 1;
                1:       la = int'(normal_max) + $urandom_range(0, 2) - 1;
                2:       la = int'(bright_max) + $urandom_range(0, 2) - 1;
                default: la = $urandom_range(0, 4095);
            endcase
            push_sample(dur, la, $urandom_range(0, 1));
        end
    endtask

    initial
    begin : stimulus
        int vmin;
        int close_thr;
        int dim;
        int normal;
        int pass_n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_sample(0, 0, 0);
        push_sample(1, 4095, 1);
        push_sample(100, 1000, 0);
        push_sample(32767, 1001, 1);
        push_sample(117, 2500, 0);
        push_sample(118, 2501, 1);
        push_sample(23533, 4095, 0);
        push_sample(23537, 0, 1);
        push_sample(30000, 2048, 0);
        push_sample(2353, 639, 1);
        push_sample(2354, 640, 0);
        push_sample(5882, 1599, 1);
        push_sample(5883, 1600, 0);
        push_sample(8000, 3000, 1);
        push_sample(12000, 1, 0);
        push_sample(16000, 4094, 1);
        push_sample(20000, 999, 0);
        push_sample(25000, 2499, 1);
        push_sample(29999, 2047, 0);
        push_random(100);
        wait_idle();

        apply_settings(32, 6400, 640, 1600, 1000, 2500, 4095, MODE_DARK_LOW);
        @(posedge clk);
        push_random(80);
        wait_idle();

        apply_settings(0, 8191, 8191, 8191, 0, 0, 0, MODE_DARK_HI);
        @(posedge clk);
        push_sample(0, 0, 1);
        push_sample(4, 0, 0);
        push_sample(30000, 0, 1);
        push_random(80);
        wait_idle();

        // inverted window rejects every reading
        apply_settings(8191, 0, 0, 0, 4095, 4095, 4095, MODE_UNUSED);
        @(posedge clk);
        push_random(60);
        wait_idle();

        apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
        @(posedge clk);
        push_random(80);
        wait_idle();

        for (pass_n = 0; pass_n < 2; pass_n++)
        begin
            vmin      = $urandom_range(0, 400);
            close_thr = $urandom_range(0, 4000);
            dim       = $urandom_range(0, 2000);
            normal    = $urandom_range(dim, 3500);
            apply_settings(vmin, $urandom_range(4000, 8191), close_thr,
                           $urandom_range(close_thr, 8191), dim, normal,
                           $urandom_range(normal, 4095), $urandom_range(0, 3));
            @(posedge clk);
            push_random(100);
            wait_idle();
        end

        repeat (64) @(negedge clk);
        if (n_errors == 0)
            $display("echo_distance_average_classifier: match");
        else
            $display("echo_distance_average_classifier: mismatch");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("echo_distance_average_classifier: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/edac_pkg.sv
rtl/edac_ctrl.sv
rtl/edac_dp.sv
rtl/echo_distance_average_classifier.sv
tb/tb_echo_distance_average_classifier.sv
